FILE: hw/rtl/dkf_pkg.sv
// Shared widths, constants and the result record type of the distinct key filter.
package dkf_pkg;

    localparam int KEY_W         = 32;
    localparam int LEN_W         = 32;
    localparam int COUNT_W       = 9;
    localparam int COUNT_MAX     = 511;
    localparam int DEPTH_DEFAULT = 256;

    // One result record as handed from the search sequencer to the output stage
    typedef struct packed {
        logic [KEY_W-1:0]   offset;
        logic [LEN_W-1:0]   length;
        logic               kept;
        logic [COUNT_W-1:0] count;
        logic               overflow;
        logic               last;
    } t_result;

endpackage

FILE: hw/rtl/dkf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dkf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/dkf_search.sv
// Search sequencer: linear scan of the seen table with one shared key comparator.
module dkf_search #(
    parameter int TABLE_DEPTH = dkf_pkg::DEPTH_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input item
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [dkf_pkg::KEY_W-1:0] i_key,
    input  logic [dkf_pkg::LEN_W-1:0] i_len,
    input  logic                    i_last,
    // result toward the output stage
    output logic                    o_res_valid,
    input  logic                    i_res_ready,
    output dkf_pkg::t_result        o_res,
    // table memory
    output logic                    o_rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_rd_addr,
    input  logic [dkf_pkg::KEY_W-1:0] i_rd_data,
    output logic                    o_wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0] o_wr_addr,
    output logic [dkf_pkg::KEY_W-1:0] o_wr_data
);
    import dkf_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int SAT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_FIN    = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_chk, n_chk;
    logic             r_found, n_found;
    logic [KEY_W-1:0] r_key;
    logic [LEN_W-1:0] r_len;
    logic             r_last;

    logic             more;
    logic             hit;
    logic             room;
    logic             insert;
    logic [CNT_W-1:0] count_new;
    logic [SAT_W-1:0] count_wide;
    logic [COUNT_W-1:0] count_sat;

    // Scan status and shared comparator
    assign more   = (r_idx < r_count);
    assign hit    = r_chk && (i_rd_data == r_key);
    assign room   = (r_count < CNT_W'(TABLE_DEPTH));
    assign insert = !r_found && room;

    // Count after this item, clipped to the field width
    always_comb begin
        count_new  = insert ? r_count + CNT_W'(1) : r_count;
        count_wide = SAT_W'(count_new);
        count_sat  = (count_wide > SAT_W'(COUNT_MAX)) ? COUNT_W'(COUNT_MAX)
                                                      : count_wide[COUNT_W-1:0];
    end

    // Sequencer
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_idx   = r_idx;
        n_chk   = 1'b0;
        n_found = r_found;
        o_rd_en = 1'b0;
        o_wr_en = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (hit) begin
                    n_found = 1'b1;
                    n_state = S_FIN;
                end else if (!more && !r_chk) begin
                    n_state = S_FIN;
                end else if (more) begin
                    o_rd_en = 1'b1;
                    n_chk   = 1'b1;
                    n_idx   = r_idx + CNT_W'(1);
                end
            end
            S_FIN: begin
                if (i_res_ready) begin
                    o_wr_en = insert;
                    n_count = r_last ? '0 : count_new;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_chk   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_chk   <= n_chk;
            r_found <= n_found;
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_key  <= i_key;
            r_len  <= i_len;
            r_last <= i_last;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_rd_addr  = r_idx[ADDR_W-1:0];
    assign o_wr_addr  = r_count[ADDR_W-1:0];
    assign o_wr_data  = r_key;

    // Result record
    assign o_res_valid    = (r_state == S_FIN);
    assign o_res.offset   = r_key;
    assign o_res.length   = r_len;
    assign o_res.kept     = !r_found;
    assign o_res.count    = count_sat;
    assign o_res.overflow = !r_found && !room;
    assign o_res.last     = r_last;

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("stored count above table depth");

    a_over_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.overflow) |-> o_res.kept)
        else $error("overflow on a repeated key");

    a_list_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && i_res_ready && r_last) |=> (r_count == '0))
        else $error("table count not cleared after end of list");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (room && o_res_valid))
        else $error("table write without room");

endmodule

FILE: hw/rtl/distinct_key_filter.sv
// Distinct key filter: passes records and flags first occurrences of each offset in a list.
// Each item is searched by a linear scan of the table RAM, one entry read a cycle through a
// single comparator: one table read per stored entry (at most TABLE_DEPTH), the last compare,
// a turnaround, then finish and output load; a match ends the scan sooner, and an empty table
// skips the reads. Items are handled one at a time: the next is taken only after finish.
// The result sits in an output register, so the next item can be taken while it waits;
// finish stalls only while that register still holds a result that is not transferred.
// Reset (i_rst_n low, synchronous) empties the table count; table contents need no clearing.
module distinct_key_filter #(
    parameter int TABLE_DEPTH = dkf_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [dkf_pkg::KEY_W-1:0]   i_offset_value,
    input  logic [dkf_pkg::LEN_W-1:0]   i_length_value,
    input  logic                        i_last_of_list,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [dkf_pkg::KEY_W-1:0]   o_offset_out,
    output logic [dkf_pkg::LEN_W-1:0]   o_length_out,
    output logic                        o_kept,
    output logic [dkf_pkg::COUNT_W-1:0] o_distinct_count,
    output logic                        o_table_overflow,
    output logic                        o_list_done
);
    import dkf_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic              res_valid;
    logic              res_ready;
    t_result           res;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [KEY_W-1:0]  rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [KEY_W-1:0]  wr_data;

    logic              r_out_valid;
    t_result           r_out;

    dkf_search #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_search (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_key      (i_offset_value),
        .i_len      (i_length_value),
        .i_last     (i_last_of_list),
        .o_res_valid(res_valid),
        .i_res_ready(res_ready),
        .o_res      (res),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd_data  (rd_data),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data)
    );

    dkf_ram #(
        .WIDTH(KEY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_seen_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // Output register: loads when empty or when its record is being transferred
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_offset_out     = r_out.offset;
    assign o_length_out     = r_out.length;
    assign o_kept           = r_out.kept;
    assign o_distinct_count = r_out.count;
    assign o_table_overflow = r_out.overflow;
    assign o_list_done      = r_out.last;

endmodule
